// ===== rtl/gbn_sw_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gbn_sw_pkg
// Shared types and codes for the Go-Back-N sender window block.
// ----------------------------------------------------------------------------
package gbn_sw_pkg;

	localparam int unsigned ID_W    = 5;
	localparam int unsigned TIMER_W = 16;
	localparam logic [TIMER_W-1:0] TIMEOUT_RST = 16'd50;

	typedef enum logic [1:0] {
		ACT_OFFER = 2'd0,
		ACT_ACK   = 2'd1,
		ACT_TICK  = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		KIND_SENT = 2'd0,
		KIND_FULL = 2'd1,
		KIND_ACK  = 2'd2,
		KIND_RETX = 2'd3
	} kind_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_OUT  = 1'b1
	} ctrl_state_t;

	typedef struct packed {
		logic exec;     // accept input transaction and update window
		logic advance;  // load next retransmit result
	} ctrl_cmd_t;

	typedef struct packed {
		logic has_result;  // current input produces at least one result
		logic more;        // retransmit results still pending
	} dp_status_t;

endpackage
`default_nettype wire

// ===== rtl/gbn_sw_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gbn_sw_ctrl
// Controller: takes one input transaction at a time and holds the block
// while its results drain through the output register.
// ----------------------------------------------------------------------------
module gbn_sw_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	input  wire gbn_sw_pkg::dp_status_t sts,
	output gbn_sw_pkg::ctrl_cmd_t      cmd
);
	import gbn_sw_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && sts.has_result) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!out_stall && !sts.more) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_stall    = 1'b1;
		out_valid   = 1'b0;
		cmd.exec    = 1'b0;
		cmd.advance = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.exec = in_valid;
			end
			ST_OUT: begin
				out_valid   = 1'b1;
				cmd.advance = !out_stall && sts.more;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/gbn_sw_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gbn_sw_dp
// Datapath: window pointers, retransmit timer, timeout register, burst
// counter and the output result register.
// ----------------------------------------------------------------------------
module gbn_sw_dp #(
	parameter int unsigned WINDOW = 7
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [gbn_sw_pkg::TIMER_W-1:0] cfg_wdata,
	input  wire logic [1:0]                     action,
	input  wire logic [gbn_sw_pkg::ID_W-1:0]    ack_id,
	input  wire gbn_sw_pkg::ctrl_cmd_t          cmd,
	output gbn_sw_pkg::dp_status_t              sts,
	output logic [1:0]                          kind,
	output logic [gbn_sw_pkg::ID_W-1:0]         seq_id,
	output logic [gbn_sw_pkg::ID_W-1:0]         outstanding,
	output logic                                timer_active,
	output logic                                last
);
	import gbn_sw_pkg::*;

	localparam int unsigned SEQ_MOD = WINDOW + 1;
	localparam int unsigned ACK_N   = (1 << ID_W) + 1;
	localparam logic [ID_W-1:0]   ID_MAX = ID_W'(WINDOW);
	localparam logic [ID_W:0]     MOD_W  = (ID_W + 1)'(SEQ_MOD);

	// (ack + 1) mod SEQ_MOD lookup
	logic [ID_W-1:0] mod_tbl [ACK_N];
	for (genvar g = 0; g < ACK_N; g++) begin : g_mod
		localparam logic [ID_W-1:0] MV = ID_W'(g % SEQ_MOD);
		assign mod_tbl[g] = MV;
	end

	function automatic logic [ID_W-1:0] seq_dist(input logic [ID_W-1:0] nxt,
		input logic [ID_W-1:0] bas);
		logic [ID_W:0] wide;
		wide = (ID_W + 1)'(nxt) + MOD_W - (ID_W + 1)'(bas);
		if (nxt >= bas) begin
			return nxt - bas;
		end
		return wide[ID_W-1:0];
	endfunction

	function automatic logic [ID_W-1:0] seq_inc(input logic [ID_W-1:0] id);
		if (id == ID_MAX) begin
			return '0;
		end
		return id + 1'b1;
	endfunction

	logic [ID_W-1:0]    next_q, base_q, cur_q, rem_q;
	logic               timer_q;
	logic [TIMER_W-1:0] elapsed_q, timeout_q;
	kind_t              kind_q;
	logic [ID_W-1:0]    seq_q, outst_q;
	logic               tact_q, last_q;

	logic [ID_W-1:0]    next_d, base_d, cur_d, rem_d;
	logic               timer_d;
	logic [TIMER_W-1:0] elapsed_d;
	kind_t              kind_d;
	logic [ID_W-1:0]    seq_d, count_now, count_new;
	logic               res_d, last_d;
	logic [ID_W:0]      ack_idx;

	assign count_now = seq_dist(next_q, base_q);
	assign ack_idx   = (ID_W + 1)'(ack_id) + 1'b1;

	always_comb begin
		next_d    = next_q;
		base_d    = base_q;
		timer_d   = timer_q;
		elapsed_d = elapsed_q;
		kind_d    = KIND_SENT;
		seq_d     = '0;
		last_d    = 1'b1;
		res_d     = 1'b0;
		cur_d     = seq_inc(base_q);
		rem_d     = '0;
		case (action_t'(action))
			ACT_OFFER: begin
				res_d = 1'b1;
				if (count_now < ID_MAX) begin
					kind_d = KIND_SENT;
					seq_d  = next_q;
					if (next_q == base_q) begin
						timer_d   = 1'b1;
						elapsed_d = '0;
					end
					next_d = seq_inc(next_q);
				end else begin
					kind_d = KIND_FULL;
				end
			end
			ACT_ACK: begin
				res_d  = 1'b1;
				kind_d = KIND_ACK;
				base_d = mod_tbl[ack_idx];
				seq_d  = base_d;
				if (next_q == base_d) begin
					timer_d = 1'b0;
				end else begin
					timer_d   = 1'b1;
					elapsed_d = '0;
				end
			end
			ACT_TICK: begin
				if (timer_q) begin
					if (elapsed_q < timeout_q) begin
						elapsed_d = elapsed_q + 1'b1;
					end else begin
						elapsed_d = '0;
						kind_d    = KIND_RETX;
						seq_d     = base_q;
						res_d     = (count_now != '0);
						last_d    = (count_now == ID_W'(1));
						rem_d     = count_now - 1'b1;
					end
				end
			end
			default: begin
				res_d = 1'b0;
			end
		endcase
	end

	assign count_new      = seq_dist(next_d, base_d);
	assign sts.has_result = res_d;
	assign sts.more       = (rem_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_q    <= '0;
			base_q    <= '0;
			timer_q   <= 1'b0;
			elapsed_q <= '0;
			timeout_q <= TIMEOUT_RST;
			rem_q     <= '0;
		end else begin
			if (cfg_we) begin
				timeout_q <= cfg_wdata;
			end
			if (cmd.exec) begin
				next_q    <= next_d;
				base_q    <= base_d;
				timer_q   <= timer_d;
				elapsed_q <= elapsed_d;
				rem_q     <= res_d ? rem_d : '0;
			end else if (cmd.advance) begin
				rem_q <= rem_q - 1'b1;
			end
		end
	end

	// result register; loaded only when the output side is empty or taken
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			kind_q  <= kind_d;
			seq_q   <= seq_d;
			outst_q <= count_new;
			tact_q  <= timer_d;
			last_q  <= last_d;
			cur_q   <= cur_d;
		end else if (cmd.advance) begin
			seq_q  <= cur_q;
			last_q <= (rem_q == ID_W'(1));
			cur_q  <= seq_inc(cur_q);
		end
	end

	assign kind         = kind_q;
	assign seq_id       = seq_q;
	assign outstanding  = outst_q;
	assign timer_active = tact_q;
	assign last         = last_q;

`ifndef SYNTHESIS
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(next_q <= ID_MAX) && (base_q <= ID_MAX))
		else $error("window pointer out of sequence range");

	a_timer_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!timer_q |-> (next_q == base_q))
		else $error("timer stopped with frames outstanding");

	a_burst_len: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q < ID_MAX)
		else $error("retransmit count exceeds window");

	a_advance_more: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.advance |-> (rem_q != '0) && !cmd.exec)
		else $error("retransmit advance with nothing pending");
`endif

endmodule
`default_nettype wire

// ===== rtl/gbn_sender_window_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gbn_sender_window_core
// Go-Back-N sender window control with tick-based retransmit timer.
//
// Input channel (in_valid/in_stall): action and ack_id. Offers and acks give
// one result; a tick gives none, or on timer expiry one retransmit result
// per outstanding id, oldest first, the final one marked by last.
// Output channel (out_valid/out_stall): kind, seq_id, outstanding,
// timer_active, last, held stable while stalled.
// cfg_we/cfg_wdata load timeout_ticks; write only while the block is idle.
// The first result appears in the cycle after the transaction is
// accepted. An item holds the block until its last result has been
// taken, so no new item is accepted while results are pending; a tick
// that gives no result does not hold it. The single output register
// sets this: the next input is taken once the last result has left it.
// Reset clears both window pointers, stops the timer and sets the timeout
// to 50 ticks. While the receiver stalls, results wait in place and
// in_stall stays high.
// ----------------------------------------------------------------------------
module gbn_sender_window_core #(
	parameter int unsigned WINDOW = 7
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [gbn_sw_pkg::TIMER_W-1:0] cfg_wdata,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [1:0]                     action,
	input  wire logic [gbn_sw_pkg::ID_W-1:0]    ack_id,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [1:0]                          kind,
	output logic [gbn_sw_pkg::ID_W-1:0]         seq_id,
	output logic [gbn_sw_pkg::ID_W-1:0]         outstanding,
	output logic                                timer_active,
	output logic                                last
);
	import gbn_sw_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t sts;

	gbn_sw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	gbn_sw_dp #(
		.WINDOW (WINDOW)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.action       (action),
		.ack_id       (ack_id),
		.cmd          (cmd),
		.sts          (sts),
		.kind         (kind),
		.seq_id       (seq_id),
		.outstanding  (outstanding),
		.timer_active (timer_active),
		.last         (last)
	);

endmodule
`default_nettype wire
